// ===== src/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file imports this package.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned OutqDepth = 3;

  localparam logic [CodeW-1:0] REPL_CHAR  = 21'h00FFFD;
  localparam logic [CodeW-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [CodeW-1:0] MIN_TWO    = 21'h000080;
  localparam logic [CodeW-1:0] MIN_THREE  = 21'h000800;

  // Extra bytes that a lead byte asks for.
  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2,
    KIND_FOUR  = 2'd3
  } lead_kind_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             run_last;
    logic             string_end;
  } res_t;

  // Results produced by one byte, oldest first.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

`default_nettype wire

// ===== src/utf8d_byte_if.sv =====
// Handshake channel carrying raw string bytes into the decoder.
// Depends on utf8d_pkg for field widths.
`default_nettype none

interface utf8d_byte_if
  import utf8d_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;
  logic             last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== src/utf8d_code_if.sv =====
// Handshake channel carrying decoded code points out of the decoder.
// Depends on utf8d_pkg for field widths.
`default_nettype none

interface utf8d_code_if
  import utf8d_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_point;
  logic             run_last;
  logic             string_end;

  modport source (output valid, output code_point, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input code_point, input run_last, input string_end,
                  output ready);
endinterface

`default_nettype wire

// ===== src/utf8d_core.sv =====
// Input register, segment state and per-byte decode of the UTF-8 decoder.
// Depends on utf8d_pkg and utf8d_byte_if.
`default_nettype none

module utf8d_core
  import utf8d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  utf8d_byte_if.sink   byte_stream,
  input  wire logic    space,
  output push_t        push
);

  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             hold_last;

  logic             segment_open;
  logic [CodeW-1:0] accum;
  lead_kind_t       lead_kind;
  logic [1:0]       bytes_taken;
  logic             segment_bad;

  logic             segment_open_next;
  logic [CodeW-1:0] accum_next;
  lead_kind_t       lead_kind_next;
  logic [1:0]       bytes_taken_next;
  logic             segment_bad_next;

  logic             process;
  logic             cont;
  logic             emit_old;
  logic [CodeW-1:0] old_value;
  logic [CodeW-1:0] end_value;

  function automatic logic [CodeW-1:0] finish(input logic [CodeW-1:0] acc,
                                              input lead_kind_t kind,
                                              input logic [1:0] taken,
                                              input logic bad);
    logic [CodeW-1:0] val;
    val = acc;
    unique case (kind)
      KIND_ASCII: val = acc;
      KIND_TWO:   if (acc < MIN_TWO && acc != '0) val = REPL_CHAR;
      KIND_THREE: if (acc < MIN_THREE) val = REPL_CHAR;
      KIND_FOUR:  if (acc > MAX_SCALAR) val = REPL_CHAR;
      default:    val = REPL_CHAR;
    endcase
    if (bad || taken < 2'(kind)) val = REPL_CHAR;
    return val;
  endfunction

  assign process           = hold_valid && space;
  assign byte_stream.ready = !hold_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= (byte_stream.valid && byte_stream.ready) || (hold_valid && !process);
    end
    if (byte_stream.valid && byte_stream.ready) begin
      hold_byte <= byte_stream.byte_in;
      hold_last <= byte_stream.last_byte;
    end
  end

  assign cont      = hold_byte[7:6] == 2'b10;
  assign emit_old  = segment_open && !cont;
  assign old_value = finish(accum, lead_kind, bytes_taken, segment_bad);

  always_comb begin
    segment_open_next = segment_open;
    accum_next        = accum;
    lead_kind_next    = lead_kind;
    bytes_taken_next  = bytes_taken;
    segment_bad_next  = segment_bad;
    if (segment_open && cont) begin
      if (!segment_bad && bytes_taken < 2'(lead_kind)) begin
        accum_next       = {accum[CodeW-7:0], hold_byte[5:0]};
        bytes_taken_next = bytes_taken + 2'd1;
      end
    end else begin
      segment_open_next = 1'b1;
      bytes_taken_next  = '0;
      segment_bad_next  = 1'b0;
      if (!hold_byte[7]) begin
        lead_kind_next = KIND_ASCII;
        accum_next     = CodeW'(hold_byte);
      end else if (hold_byte[7:5] == 3'b110) begin
        lead_kind_next = KIND_TWO;
        accum_next     = CodeW'(hold_byte[4:0]);
      end else if (hold_byte[7:4] == 4'b1110) begin
        // The three-byte lead keeps five payload bits; the bit above the four
        // real ones is always zero here, so values below 0x800 catch overlongs.
        lead_kind_next = KIND_THREE;
        accum_next     = CodeW'(hold_byte[4:0]);
      end else if (hold_byte[7:3] == 5'b11110) begin
        lead_kind_next = KIND_FOUR;
        accum_next     = CodeW'(hold_byte[2:0]);
      end else begin
        lead_kind_next   = KIND_ASCII;
        accum_next       = '0;
        segment_bad_next = 1'b1;
      end
    end
  end

  assign end_value = finish(accum_next, lead_kind_next, bytes_taken_next, segment_bad_next);

  always_comb begin
    push.count             = process ? (2'(emit_old) + 2'(hold_last)) : 2'd0;
    push.first.code_point  = emit_old ? old_value : end_value;
    push.first.run_last    = !(emit_old && hold_last);
    push.first.string_end  = !emit_old;
    push.second.code_point = end_value;
    push.second.run_last   = 1'b1;
    push.second.string_end = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_open <= 1'b0;
      accum        <= '0;
      lead_kind    <= KIND_ASCII;
      bytes_taken  <= '0;
      segment_bad  <= 1'b0;
    end else if (process) begin
      if (hold_last) begin
        // The string is finished, so the next byte starts afresh.
        segment_open <= 1'b0;
        accum        <= '0;
        lead_kind    <= KIND_ASCII;
        bytes_taken  <= '0;
        segment_bad  <= 1'b0;
      end else begin
        segment_open <= segment_open_next;
        accum        <= accum_next;
        lead_kind    <= lead_kind_next;
        bytes_taken  <= bytes_taken_next;
        segment_bad  <= segment_bad_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (process && hold_last) |=> !segment_open)
    else $error("segment still open after the final byte of a string");

  a_two_needs_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (hold_last && segment_open))
    else $error("two words produced without an open segment and a final byte");

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !process |-> (push.count == 2'd0))
    else $error("words produced while no byte is processed");

  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    segment_open |-> (bytes_taken <= 2'(lead_kind)))
    else $error("more continuation bytes taken than the lead asked for");
`endif

endmodule

`default_nettype wire

// ===== src/utf8d_outq.sv =====
// Small shifting result queue that decouples the decode from the output sink.
// Depends on utf8d_pkg and utf8d_code_if.
`default_nettype none

module utf8d_outq
  import utf8d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  output logic         space,
  utf8d_code_if.source code_stream
);

  localparam int unsigned CntW = $clog2(OutqDepth + 1);

  res_t            slot      [OutqDepth];
  res_t            slot_next [OutqDepth];
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [CntW-1:0] base;
  logic            pop;

  assign pop                    = code_stream.valid && code_stream.ready;
  assign code_stream.valid      = count != '0;
  assign code_stream.code_point = slot[0].code_point;
  assign code_stream.run_last   = slot[0].run_last;
  assign code_stream.string_end = slot[0].string_end;

  // Room for two words is kept, whatever the sink does this cycle.
  assign space = count <= CntW'(OutqDepth - 2);

  assign base       = count - CntW'(pop);
  assign count_next = base + CntW'(push.count);

  always_comb begin
    for (int i = 0; i < OutqDepth; i++) begin
      slot_next[i] = slot[i];
    end
    if (pop) begin
      for (int i = 0; i < OutqDepth - 1; i++) begin
        slot_next[i] = slot[i + 1];
      end
    end
    for (int i = 0; i < OutqDepth; i++) begin
      if (push.count != 2'd0 && CntW'(i) == base) begin
        slot_next[i] = push.first;
      end
      if (push.count == 2'd2 && CntW'(i) == base + CntW'(1)) begin
        slot_next[i] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < OutqDepth; i++) begin
      slot[i] <= slot_next[i];
    end
  end

`ifndef SYNTHESIS
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= CntW'(OutqDepth - 2)))
    else $error("words pushed without room for two");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && count == CntW'(1) && push.count == 2'd0) |=> !code_stream.valid)
    else $error("queue not empty after its only word left");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (code_stream.valid && !code_stream.ready) |=> $stable(code_stream.code_point))
    else $error("head word changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== src/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: takes one byte per clock and gives one code point per
// segment (0xFFFD for a malformed one). A byte is registered on entry, decoded
// against the segment state once the queue has room, and its words go into a
// three-word output queue of registered slots that feeds the sink. A byte that
// starts a new segment and also ends the string gives two words together;
// the decode then waits while the queue holds more than one word, so sustained
// input is one byte per clock whenever the sink takes one word per clock, except
// that each such two-word byte can hold up the input at the end of its string.
// Depends on utf8d_pkg, the two channel interfaces, utf8d_core and utf8d_outq.
`default_nettype none

module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  utf8d_byte_if.sink   byte_stream,
  utf8d_code_if.source code_stream
);

  push_t push;
  logic  space;

  utf8d_core u_core (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .space       (space),
    .push        (push)
  );

  utf8d_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .space       (space),
    .code_stream (code_stream)
  );

endmodule

`default_nettype wire
